>>> rtl/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg: shared types and constants of the turtle path interpreter
// Command and result codes, fixed-point widths, the pen/stack entry type,
// the quarter-wave sine table and the saturation and degree helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

  // sizes
  localparam int STACK_DEPTH = 128;
  localparam int FRAC_BITS   = 8;
  localparam int POS_W       = 24;
  localparam int HEAD_W      = 9;
  localparam int STEP_W      = 10;
  localparam int TURN_W      = 9;
  localparam int START_W     = 16;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // angles in whole degrees
  localparam int DEG_FULL      = 360;
  localparam int DEG_QUARTER   = 90;
  localparam int HEADING_RESET = 90;
  localparam int TURN_RESET    = 25;
  localparam int STEP_RESET    = 20;

  // sine table in Q1.14, one quarter wave
  localparam int TRIG_FRAC = 14;
  localparam int TRIG_W    = 16;
  localparam int QMAG_W    = 15;
  localparam int QTAB_N    = DEG_QUARTER + 1;
  localparam int QIDX_W    = $clog2(QTAB_N);
  localparam logic [63:0] RAD_Q30 = 64'd18740330;

  // move scaling from Q1.14 times whole units down to Q.FRAC_BITS
  localparam int MOVE_RSH  = (FRAC_BITS < TRIG_FRAC) ? TRIG_FRAC - FRAC_BITS : 0;
  localparam int MOVE_LSH  = (FRAC_BITS > TRIG_FRAC) ? FRAC_BITS - TRIG_FRAC : 0;
  localparam int ROUND_ADD = (1 << MOVE_RSH) >> 1;
  localparam int PROD_W    = QMAG_W + STEP_W;
  localparam int MAG_W     = PROD_W + 1 + MOVE_LSH;
  localparam int MOVE_W    = MAG_W + 1;
  localparam int SUM_W     = ((MOVE_W > POS_W) ? MOVE_W : POS_W) + 1;
  localparam int SAT_IN_W  = 32;

  // command codes
  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_FORWARD = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_RIGHT  = 3'd4,
    CMD_LEFT   = 3'd5,
    CMD_LEAF   = 3'd6,
    CMD_IGNORE = 3'd7
  } cmd_t;

  // result codes
  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_LINE      = 3'd1,
    KIND_MOVE      = 3'd2,
    KIND_LEAF      = 3'd3,
    KIND_OVERFLOW  = 3'd4,
    KIND_UNDERFLOW = 3'd5
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_ANGLE  = 2'd0,
    REG_STEP_LENGTH = 2'd1,
    REG_DRAW_MODE   = 2'd2,
    REG_LEAF_ENABLE = 2'd3
  } cfg_reg_t;

  typedef logic signed [POS_W-1:0] pos_t;

  // pen position and heading, also one stack entry
  typedef struct packed {
    pos_t              x;
    pos_t              y;
    logic [HEAD_W-1:0] heading;
  } pen_t;

  // stack write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    pen_t              data;
  } stack_wr_t;

  typedef logic [QTAB_N-1:0][QMAG_W-1:0] quarter_table_t;

  // quarter-wave sine, Q30 series up to the x^13 term, rounded to Q14
  function automatic quarter_table_t build_quarter_sine();
    quarter_table_t tab;
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    term;
    logic [63:0]    sum;
    for (int d = 0; d < QTAB_N; d++) begin
      x    = 64'(d) * RAD_Q30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      tab[d] = QMAG_W'((sum + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam quarter_table_t QUARTER_SINE = build_quarter_sine();

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = (1 <<< (POS_W - 1)) - 1;
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -(1 <<< (POS_W - 1));

  // clamp a wide signed value to the position range
  function automatic pos_t sat_pos(input logic signed [SAT_IN_W-1:0] v);
    pos_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[POS_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // fold a 9-bit angle into 0..359
  function automatic logic [HEAD_W-1:0] wrap_deg(input logic [HEAD_W-1:0] v);
    logic [HEAD_W-1:0] r;
    if (v >= HEAD_W'(DEG_FULL)) begin
      r = v - HEAD_W'(DEG_FULL);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tpi_stack_ram.sv
// ----------------------------------------------------------------------------
// tpi_stack_ram: storage for saved pen entries below the top of stack
// One write port and one registered read port; a read of the address written
// in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_stack_ram
  import tpi_pkg::*;
(
  input  wire logic              clk,
  input  wire stack_wr_t         wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output pen_t                   rd_data
);

  pen_t mem [STACK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read with write-through
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tpi_motion.sv
// ----------------------------------------------------------------------------
// tpi_motion: pen position after one forward step
// Looks up cosine and sine of the heading, scales them by the step length,
// rounds half away from zero and adds them to the pen with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_motion
  import tpi_pkg::*;
(
  input  wire pen_t              pen,
  input  wire logic [STEP_W-1:0] step_length,
  output pos_t                   x_next,
  output pos_t                   y_next
);

  // sine of a heading in 0..359, Q1.14
  function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [HEAD_W-1:0] deg);
    logic [HEAD_W-1:0] r;
    logic [1:0]        q;
    logic [QIDX_W-1:0] idx;
    logic [QMAG_W-1:0] mag;
    if (deg < HEAD_W'(DEG_QUARTER)) begin
      q = 2'd0;
      r = deg;
    end else if (deg < HEAD_W'(2 * DEG_QUARTER)) begin
      q = 2'd1;
      r = deg - HEAD_W'(DEG_QUARTER);
    end else if (deg < HEAD_W'(3 * DEG_QUARTER)) begin
      q = 2'd2;
      r = deg - HEAD_W'(2 * DEG_QUARTER);
    end else begin
      q = 2'd3;
      r = deg - HEAD_W'(3 * DEG_QUARTER);
    end
    idx = q[0] ? QIDX_W'(HEAD_W'(DEG_QUARTER) - r) : r[QIDX_W-1:0];
    mag = QUARTER_SINE[idx];
    return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // step_length times a Q1.14 factor, rounded half away from zero
  function automatic logic signed [MOVE_W-1:0] scale_move(
    input logic signed [TRIG_W-1:0] trig,
    input logic [STEP_W-1:0]        step
  );
    logic [QMAG_W-1:0] mag_abs;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  mag;
    mag_abs = trig[TRIG_W-1] ? QMAG_W'(-trig) : QMAG_W'(trig);
    prod    = PROD_W'(mag_abs) * PROD_W'(step);
    mag     = ((MAG_W'(prod) + MAG_W'(ROUND_ADD)) >> MOVE_RSH) << MOVE_LSH;
    return trig[TRIG_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic [HEAD_W:0]           cos_sum;
  logic [HEAD_W-1:0]         cos_deg;
  logic signed [TRIG_W-1:0]  trig_cos;
  logic signed [TRIG_W-1:0]  trig_sin;
  logic signed [MOVE_W-1:0]  move_x;
  logic signed [MOVE_W-1:0]  move_y;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;

  // cosine is the sine a quarter turn further on
  always_comb begin
    cos_sum = (HEAD_W + 1)'(pen.heading) + (HEAD_W + 1)'(DEG_QUARTER);
    if (cos_sum >= (HEAD_W + 1)'(DEG_FULL)) begin
      cos_deg = HEAD_W'(cos_sum - (HEAD_W + 1)'(DEG_FULL));
    end else begin
      cos_deg = cos_sum[HEAD_W-1:0];
    end
  end

  assign trig_cos = sine_q14(cos_deg);
  assign trig_sin = sine_q14(pen.heading);

  // scale, add and clamp
  assign move_x = scale_move(trig_cos, step_length);
  assign move_y = scale_move(trig_sin, step_length);
  assign sum_x  = SUM_W'(pen.x) + SUM_W'(move_x);
  assign sum_y  = SUM_W'(pen.y) + SUM_W'(move_y);
  assign x_next = sat_pos(SAT_IN_W'(sum_x));
  assign y_next = sat_pos(SAT_IN_W'(sum_y));

endmodule

`default_nettype wire

>>> rtl/turtle_path_interpreter.sv
// ----------------------------------------------------------------------------
// turtle_path_interpreter: turtle command stream to path segments
// Usage:
//   Commands enter on the in channel (in_valid/in_stall) with their start
//   fields; each accepted command gives exactly one result on the out
//   channel (out_valid/out_stall): kind, pen before and after, and the box.
//   Registers turn_angle, step_length, draw_mode and leaf_enable are written
//   through cfg_write/cfg_index/cfg_data; the user must write them only
//   while no command is in flight, which the block itself does not enforce.
//   A command is captured in an input register, worked by the trig lookup,
//   a 15x10 multiply and a saturating add, and lands in the result register.
//   Throughput is one command per cycle while the receiver does not stall,
//   set by the joint update of pen, heading and stack; pushes and pops keep
//   the top entry in flops and the next entry prefetched from the stack RAM,
//   so they run back to back.
//   When the receiver stalls, the result register holds and in_stall rises
//   once the input register is also occupied; nothing is dropped.
//   Reset: pen at the origin heading 90 degrees, stack empty, box zero,
//   registers back to their defaults. The stack RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_path_interpreter
  import tpi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // commands
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           command,
  input  wire logic signed [START_W-1:0] start_x,
  input  wire logic signed [START_W-1:0] start_y,
  input  wire logic [HEAD_W-1:0]    start_heading,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                kind,
  output pos_t                      from_x,
  output pos_t                      from_y,
  output pos_t                      to_x,
  output pos_t                      to_y,
  output pos_t                      bound_min_x,
  output pos_t                      bound_max_x,
  output pos_t                      bound_min_y,
  output pos_t                      bound_max_y
);

  // configuration registers
  logic [TURN_W-1:0] turn_angle;
  logic [STEP_W-1:0] step_length;
  logic              draw_mode;
  logic              leaf_enable;

  // input register
  logic                     s1_valid;
  cmd_t                     s1_command;
  logic signed [START_W-1:0] s1_start_x;
  logic signed [START_W-1:0] s1_start_y;
  logic [HEAD_W-1:0]        s1_start_heading;

  // turtle state
  pen_t              pen;
  pen_t              tos;
  logic [FILL_W-1:0] fill;
  pos_t              box_min_x;
  pos_t              box_max_x;
  pos_t              box_min_y;
  pos_t              box_max_y;

  // next values
  pen_t              pen_next;
  pen_t              tos_next;
  logic [FILL_W-1:0] fill_next;
  pos_t              box_min_x_next;
  pos_t              box_max_x_next;
  pos_t              box_min_y_next;
  pos_t              box_max_y_next;
  kind_t             kind_next;

  logic              advance;
  logic              in_take;
  stack_wr_t         stack_wr;
  logic [ADDR_W-1:0] below_addr;
  pen_t              below;
  pos_t              fwd_x;
  pos_t              fwd_y;
  logic [HEAD_W-1:0] turn_deg;
  logic [HEAD_W:0]   head_left;
  logic [HEAD_W:0]   head_right;

  // handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_angle  <= TURN_W'(TURN_RESET);
      step_length <= STEP_W'(STEP_RESET);
      draw_mode   <= 1'b0;
      leaf_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TURN_ANGLE:  turn_angle  <= cfg_data[TURN_W-1:0];
        REG_STEP_LENGTH: step_length <= cfg_data[STEP_W-1:0];
        REG_DRAW_MODE:   draw_mode   <= cfg_data[0];
        REG_LEAF_ENABLE: leaf_enable <= cfg_data[0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_command       <= CMD_IGNORE;
    end else if (in_take) begin
      s1_command       <= cmd_t'(command);
      s1_start_x       <= start_x;
      s1_start_y       <= start_y;
      s1_start_heading <= start_heading;
    end
  end

  // forward step datapath
  tpi_motion u_motion (
    .pen         (pen),
    .step_length (step_length),
    .x_next      (fwd_x),
    .y_next      (fwd_y)
  );

  // turn arithmetic
  assign turn_deg   = wrap_deg(turn_angle);
  assign head_left  = (HEAD_W + 1)'(pen.heading) + (HEAD_W + 1)'(turn_deg);
  assign head_right = (HEAD_W + 1)'(pen.heading) - (HEAD_W + 1)'(turn_deg);

  // command decode and next state
  always_comb begin
    pen_next       = pen;
    tos_next       = tos;
    fill_next      = fill;
    box_min_x_next = box_min_x;
    box_max_x_next = box_max_x;
    box_min_y_next = box_min_y;
    box_max_y_next = box_max_y;
    kind_next      = KIND_NONE;
    stack_wr       = '0;
    unique case (s1_command)
      CMD_START: begin
        pen_next.x       = sat_pos(SAT_IN_W'(s1_start_x) <<< FRAC_BITS);
        pen_next.y       = sat_pos(SAT_IN_W'(s1_start_y) <<< FRAC_BITS);
        pen_next.heading = wrap_deg(s1_start_heading);
      end
      CMD_FORWARD: begin
        pen_next.x = fwd_x;
        pen_next.y = fwd_y;
        if (draw_mode) begin
          kind_next = KIND_LINE;
        end else begin
          kind_next = KIND_MOVE;
          if (fwd_x < box_min_x) box_min_x_next = fwd_x;
          if (fwd_x > box_max_x) box_max_x_next = fwd_x;
          if (fwd_y < box_min_y) box_min_y_next = fwd_y;
          if (fwd_y > box_max_y) box_max_y_next = fwd_y;
        end
      end
      CMD_PUSH: begin
        if (fill == FILL_W'(STACK_DEPTH)) begin
          kind_next = KIND_OVERFLOW;
        end else begin
          // old top moves into the RAM, pen becomes the new top
          stack_wr.en   = (fill != '0);
          stack_wr.addr = ADDR_W'(fill - FILL_W'(1));
          stack_wr.data = tos;
          tos_next      = pen;
          fill_next     = fill + FILL_W'(1);
        end
      end
      CMD_POP: begin
        if (fill == '0) begin
          kind_next = KIND_UNDERFLOW;
        end else begin
          pen_next  = tos;
          tos_next  = below;
          fill_next = fill - FILL_W'(1);
        end
      end
      CMD_RIGHT: begin
        if (head_right[HEAD_W]) begin
          pen_next.heading = HEAD_W'(head_right + (HEAD_W + 1)'(DEG_FULL));
        end else begin
          pen_next.heading = head_right[HEAD_W-1:0];
        end
      end
      CMD_LEFT: begin
        if (head_left >= (HEAD_W + 1)'(DEG_FULL)) begin
          pen_next.heading = HEAD_W'(head_left - (HEAD_W + 1)'(DEG_FULL));
        end else begin
          pen_next.heading = head_left[HEAD_W-1:0];
        end
      end
      CMD_LEAF: begin
        if (leaf_enable) kind_next = KIND_LEAF;
      end
      CMD_IGNORE: begin
      end
    endcase
  end

  // prefetch the entry just below the new top
  assign below_addr = ADDR_W'(fill_next - FILL_W'(2));

  tpi_stack_ram u_stack (
    .clk     (clk),
    .wr      (stack_wr),
    .rd_en   (advance),
    .rd_addr (below_addr),
    .rd_data (below)
  );

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pen.x       <= '0;
      pen.y       <= '0;
      pen.heading <= HEAD_W'(HEADING_RESET);
      fill        <= '0;
      box_min_x   <= '0;
      box_max_x   <= '0;
      box_min_y   <= '0;
      box_max_y   <= '0;
    end else if (advance) begin
      pen       <= pen_next;
      fill      <= fill_next;
      box_min_x <= box_min_x_next;
      box_max_x <= box_max_x_next;
      box_min_y <= box_min_y_next;
      box_max_y <= box_max_y_next;
    end
  end

  // top of stack entry
  always_ff @(posedge clk) begin
    if (advance) begin
      tos <= tos_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      kind        <= kind_next;
      from_x      <= pen.x;
      from_y      <= pen.y;
      to_x        <= pen_next.x;
      to_y        <= pen_next.y;
      bound_min_x <= box_min_x_next;
      bound_max_x <= box_max_x_next;
      bound_min_y <= box_min_y_next;
      bound_max_y <= box_max_y_next;
    end
  end

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    pen.heading < HEAD_W'(DEG_FULL))
    else $error("heading out of range");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
    else $error("bounding box inverted");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_PUSH) && (fill == FILL_W'(STACK_DEPTH))
    |=> (kind == KIND_OVERFLOW) && (fill == $past(fill)))
    else $error("full push not reported as overflow");

  a_pop_restore: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_POP) && (fill != '0)
    |=> (pen == $past(tos)) && (fill == $past(fill) - FILL_W'(1)))
    else $error("pop did not restore the saved pen");

endmodule

`default_nettype wire
